// ===== src/kbt_pkg.sv =====
// shared constants and codes for the key blocklist table
package kbt_pkg;

	localparam int KEY_HIGH_W  = 16;
	localparam int KEY_LOW_W   = 64;
	localparam int KEY_W       = KEY_HIGH_W + KEY_LOW_W;
	localparam int SLOT_W      = 6;
	localparam int MARKER_W    = 8;
	localparam int DEF_ENTRIES = 64;

	// marker byte that makes a loaded slot occupied
	localparam logic [MARKER_W-1:0] MARKER_OCCUPIED = 8'h00;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_LOAD   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

endpackage

// ===== src/kbt_ifs.sv =====
// command and response channel interfaces
interface kbt_cmd_if
	import kbt_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [KEY_HIGH_W-1:0] key_high;
	logic [KEY_LOW_W-1:0]  key_low;
	logic [SLOT_W-1:0]     slot;
	logic [MARKER_W-1:0]   marker;

	modport source (output valid, action, key_high, key_low, slot, marker, input ready);
	modport sink   (input valid, action, key_high, key_low, slot, marker, output ready);
endinterface

interface kbt_rsp_if
	import kbt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot_used;

	modport source (output valid, status, slot_used, input ready);
	modport sink   (input valid, status, slot_used, output ready);
endinterface

// ===== src/kbt_ram.sv =====
// generic single-port ram with registered read
module kbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/kbt_seq.sv =====
// sequencer: valid marks, key scan, write-back and response register
module kbt_seq
	import kbt_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES,
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	kbt_cmd_if.sink          cmd,
	kbt_rsp_if.source        rsp,
	output logic             ram_we,
	output logic [IDX_W-1:0] ram_addr,
	output logic [KEY_W-1:0] ram_wdata,
	input  logic [KEY_W-1:0] ram_rdata
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_RESP
	} state_t;

	state_t             state_q;
	action_t            act_q;
	logic [KEY_W-1:0]   key_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	status_t            res_status_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic               rsp_vld_q;
	status_t            rsp_status_q;
	logic [SLOT_W-1:0]  rsp_slot_q;

	logic               accept;
	logic               load_in_range;
	logic [IDX_W-1:0]   load_idx;
	logic [IDX_W-1:0]   rd_idx;
	logic               issue;
	logic               cmp_hit;
	logic               scan_end;
	logic               add_write;

	assign accept        = cmd.valid && cmd.ready;
	assign load_in_range = (32'(cmd.slot) < ENTRIES);
	assign load_idx      = IDX_W'(cmd.slot);
	assign rd_idx        = rd_idx_q[IDX_W-1:0];
	assign issue         = (state_q == S_SCAN) && !hit_q && (32'(rd_idx_q) < ENTRIES);
	assign cmp_hit       = cmp_vld_s1 && valid_q[cmp_idx_s1] && (ram_rdata == key_q);
	assign scan_end      = (32'(rd_idx_q) >= ENTRIES) && !cmp_vld_s1;
	assign add_write     = (state_q == S_FINISH) && (act_q == ACT_ADD) && !hit_q
	                       && free_found_q;

	// ram port: load writes on acceptance, add writes back after the scan
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = rd_idx;
		ram_wdata = key_q;
		if (state_q == S_IDLE) begin
			ram_addr  = load_idx;
			ram_wdata = {cmd.key_high, cmd.key_low};
			ram_we    = accept && (action_t'(cmd.action) == ACT_LOAD) && load_in_range
			            && (cmd.marker == MARKER_OCCUPIED);
		end else if (state_q == S_FINISH) begin
			ram_addr = free_idx_q;
			ram_we   = add_write;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			act_q        <= ACT_ADD;
			key_q        <= '0;
			valid_q      <= '0;
			rd_idx_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			res_status_q <= ST_DONE;
			res_slot_q   <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_slot_q   <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q        <= action_t'(cmd.action);
						key_q        <= {cmd.key_high, cmd.key_low};
						rd_idx_q     <= '0;
						cmp_vld_s1   <= 1'b0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						res_status_q <= ST_DONE;
						res_slot_q   <= '0;
						case (action_t'(cmd.action))
							ACT_ADD, ACT_DELETE: begin
								state_q <= S_SCAN;
							end
							ACT_CLEAR: begin
								valid_q <= '0;
								state_q <= S_RESP;
							end
							ACT_LOAD: begin
								if (load_in_range) begin
									valid_q[load_idx] <= (cmd.marker == MARKER_OCCUPIED);
									res_slot_q        <= cmd.slot;
								end else begin
									res_status_q <= ST_NOT_FOUND;
								end
								state_q <= S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					// read issue side: one slot per cycle, lowest free slot noted
					cmp_vld_s1 <= issue;
					cmp_idx_s1 <= rd_idx;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (!valid_q[rd_idx] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= rd_idx;
						end
					end
					// compare side: read data of the previous cycle
					if (cmp_hit) begin
						hit_q      <= 1'b1;
						hit_idx_q  <= cmp_idx_s1;
						cmp_vld_s1 <= 1'b0;
						state_q    <= S_FINISH;
					end else if (scan_end) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (act_q == ACT_ADD) begin
						if (hit_q) begin
							res_status_q <= ST_PRESENT;
						end else if (free_found_q) begin
							valid_q[free_idx_q] <= 1'b1;
							res_slot_q          <= SLOT_W'(free_idx_q);
						end else begin
							res_status_q <= ST_FULL;
						end
					end else begin
						if (hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
							res_slot_q         <= SLOT_W'(hit_idx_q);
						end else begin
							res_status_q <= ST_NOT_FOUND;
						end
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q    <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_slot_q   <= res_slot_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_vld_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.slot_used = rsp_slot_q;
endmodule

// ===== src/key_blocklist_table_core.sv =====
// top level of the key blocklist table
//
// Table of ENTRIES 80-bit keys held in one single-port ram with a registered
// read, plus one valid flop per slot that reset and the clear action zero at
// once. Every command word yields exactly one response word. Add and delete
// walk the slots one per cycle through the ram read port, comparing each key
// read back against the command key in the cycle after its read; the walk
// stops early on a match. An add or delete passes from acceptance through
// the scan, finish and response steps into the output register; clear and
// load go straight to the response step. Only one command is worked on at a
// time; a new command is taken as soon as the previous response has moved to
// the output register, even if that word is still waiting to be taken.
// Keys of slots never written are never compared, so the ram needs no clear.
module key_blocklist_table_core
	import kbt_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input logic       clk,
	input logic       arst_n,
	kbt_cmd_if.sink   cmd,
	kbt_rsp_if.source rsp
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// key ram port driven by the sequencer
	logic             ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [KEY_W-1:0] ram_wdata;
	logic [KEY_W-1:0] ram_rdata;

	// control: slot walk, valid flops, write-back, response register
	kbt_seq #(
		.ENTRIES (ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	// key storage, one 80-bit word per slot
	kbt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);
endmodule

// ===== src/kbt_chk.sv =====
// port-level checks for the key blocklist table, bound to the top level
module kbt_chk
	import kbt_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        rsp_status,
	input logic [SLOT_W-1:0] rsp_slot_used
);
	// one command in flight: no acceptance right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted back to back");

	// a failed action reports slot zero
	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_slot_used == '0))
		else $error("nonzero slot on failed action");

	// a reported slot lies inside the table
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_slot_used) < ENTRIES))
		else $error("slot beyond table");

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
		&& $stable(rsp_slot_used)))
		else $error("stalled response changed");
endmodule

bind key_blocklist_table_core kbt_chk #(
	.ENTRIES (ENTRIES)
) u_kbt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_slot_used (rsp.slot_used)
);
